// File: design/soc_pkg.sv
// Shared types and constants for the segment obstacle clearance block.
// No dependencies.
package soc_pkg;
   localparam int DEPTH_DEFAULT = 64;
   localparam int COORD_DEFAULT = 24;
   localparam int IDX_BITS = 6;
   localparam int RAD_BITS = 16;
   localparam int TOL_BITS = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd300;
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // query context carried along the check pipeline
   typedef struct packed {
      logic        escape;
      logic [RAD_BITS-1:0] agent_r;
      logic [TOL_BITS-1:0] tol;
   } query_ctl_type;
endpackage

// File: design/segment_obstacle_clearance_top.sv
// Top level of the segment obstacle clearance block.
// Depends on soc_pkg, soc_slot, soc_check.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_ready op, index, points, height, radius, escape
//   rsp      out        rsp_valid/rsp_ready path_clear, write_rejected
//   csr      in         csr_we              csr_wdata (height tolerance)
//
// A write or remove shows its result the cycle after it is accepted; the next
// request is taken only once that result is taken. A query rotates the ring of
// slot cells once past the 6-stage check unit; its result is registered when the
// last slot leaves the check unit, and no new request is taken before then.
// One request at a time; the result register holds while rsp_ready is low, and
// req_ready drops until it is taken.
// Reset empties every slot at once; nothing else needs clearing.
module segment_obstacle_clearance_top import soc_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT,
   parameter int COORD_BITS = COORD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [IDX_BITS-1:0]          req_entry_index,
   input  logic signed [COORD_BITS-1:0] req_point_a_x,
   input  logic signed [COORD_BITS-1:0] req_point_a_y,
   input  logic signed [COORD_BITS-1:0] req_point_b_x,
   input  logic signed [COORD_BITS-1:0] req_point_b_y,
   input  logic signed [COORD_BITS-1:0] req_height_z,
   input  logic [RAD_BITS-1:0]          req_radius,
   input  logic                         req_allow_escape,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_path_clear,
   output logic                         rsp_write_rejected,
   input  logic                         csr_we,
   input  logic [TOL_BITS-1:0]          csr_wdata
);
   localparam int CB = $clog2(TABLE_DEPTH + 1);

   logic [TOL_BITS-1:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_we) tol_ff <= csr_wdata;
   end

   // sequencer
   logic busy_ff, scan_ff, blocked_ff;
   logic [CB-1:0] cnt_ff, drain_ff;
   logic accept, is_q;
   assign req_ready = !busy_ff && !rsp_valid;
   assign accept = req_valid && req_ready;
   assign is_q = req_op == OP_QUERY;

   // hold the query
   logic signed [COORD_BITS-1:0] qax_ff, qay_ff, qbx_ff, qby_ff, qz_ff;
   query_ctl_type qctl_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         qax_ff <= req_point_a_x; qay_ff <= req_point_a_y;
         qbx_ff <= req_point_b_x; qby_ff <= req_point_b_y;
         qz_ff <= req_height_z;
         qctl_ff.escape <= req_allow_escape;
         qctl_ff.agent_r <= req_radius;
         qctl_ff.tol <= tol_ff;
      end
   end

   // ring of slot cells; cell 0 feeds the check unit and takes cell 1, the last cell takes cell 0
   logic v [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] x [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] y [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] z [TABLE_DEPTH];
   logic [RAD_BITS-1:0] r [TABLE_DEPTH];
   logic wr_hit, rm_hit;
   assign wr_hit = accept && req_op == OP_WRITE && req_radius != '0;
   assign rm_hit = accept && req_op == OP_REMOVE;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
      localparam int NB = (i + 1) % TABLE_DEPTH;
      logic sel;
      assign sel = 32'(req_entry_index) == i;
      soc_slot #(.COORD_BITS(COORD_BITS)) u_slot (
         .clock, .reset,
         .load(wr_hit && sel), .clear(rm_hit && sel), .shift(scan_ff),
         .ld_x(req_point_a_x), .ld_y(req_point_a_y), .ld_z(req_height_z),
         .ld_r(req_radius),
         .nb_v(v[NB]), .nb_x(x[NB]), .nb_y(y[NB]), .nb_z(z[NB]), .nb_r(r[NB]),
         .v_ff(v[i]), .x_ff(x[i]), .y_ff(y[i]), .z_ff(z[i]), .r_ff(r[i])
      );
   end

   logic chk_v, chk_b;
   soc_check #(.COORD_BITS(COORD_BITS)) u_check (
      .clock, .reset,
      .in_valid(scan_ff), .in_live(v[0]),
      .ax(qax_ff), .ay(qay_ff), .bx(qbx_ff), .by(qby_ff), .hz(qz_ff),
      .cx(x[0]), .cy(y[0]), .cz(z[0]), .cr(r[0]),
      .ctl(qctl_ff),
      .out_valid(chk_v), .out_block(chk_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; scan_ff <= 1'b0; rsp_valid <= 1'b0;
         cnt_ff <= '0; drain_ff <= '0; blocked_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (accept) begin
            blocked_ff <= 1'b0;
            if (is_q) begin
               busy_ff <= 1'b1; scan_ff <= 1'b1;
               cnt_ff <= CB'(TABLE_DEPTH); drain_ff <= CB'(TABLE_DEPTH);
            end else begin
               rsp_valid <= 1'b1;
               rsp_path_clear <= 1'b0;
               rsp_write_rejected <= req_op == OP_WRITE && req_radius == '0;
            end
         end
         // advance the ring one slot per cycle
         if (scan_ff) begin
            cnt_ff <= cnt_ff - CB'(1);
            if (cnt_ff == CB'(1)) scan_ff <= 1'b0;
         end
         if (chk_v) begin
            if (chk_b) blocked_ff <= 1'b1;
            drain_ff <= drain_ff - CB'(1);
            if (drain_ff == CB'(1)) begin
               busy_ff <= 1'b0;
               rsp_valid <= 1'b1;
               rsp_path_clear <= !(blocked_ff || chk_b);
               rsp_write_rejected <= 1'b0;
            end
         end
      end
   end
endmodule

// File: design/soc_check.sv
// One check cell: tests one stored obstacle against the query segment.
// Pipelined over several stages; depends on soc_pkg.
module soc_check import soc_pkg::*; #(
   parameter int COORD_BITS = COORD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_live,
   input  logic signed [COORD_BITS-1:0] ax, ay, bx, by, hz,
   input  logic signed [COORD_BITS-1:0] cx, cy, cz,
   input  logic [RAD_BITS-1:0]          cr,
   input  query_ctl_type                ctl,
   output logic                         out_valid,
   output logic                         out_block
);
   localparam int D = COORD_BITS + 1;
   localparam int P = 2 * D;
   localparam int RB = RAD_BITS + 1;
   localparam int K = (P + 2) / 2;
   localparam int HB = P + 1 - K;

   // stage 1: differences
   logic s1_ff, live1_ff, esc1_ff;
   logic signed [D-1:0] ux_ff, uy_ff, sx_ff, sy_ff, vx_ff, vy_ff;
   logic [D-1:0] dz_ff;
   logic [TOL_BITS-1:0] tol1_ff;
   logic [RB-1:0] r1_ff;
   logic signed [D-1:0] dz_in;
   assign dz_in = D'(hz) - D'(cz);

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= 1'b0;
      else s1_ff <= in_valid;
      live1_ff <= in_live;
      esc1_ff <= ctl.escape;
      ux_ff <= D'(cx) - D'(ax);
      uy_ff <= D'(cy) - D'(ay);
      sx_ff <= D'(bx) - D'(ax);
      sy_ff <= D'(by) - D'(ay);
      vx_ff <= D'(cx) - D'(bx);
      vy_ff <= D'(cy) - D'(by);
      dz_ff <= dz_in[D-1] ? D'(-dz_in) : D'(dz_in);
      tol1_ff <= ctl.tol;
      r1_ff <= RB'(ctl.agent_r) + RB'(cr);
   end

   // stage 2: products (signed but for the radius square, one register after each), height test
   logic s2_ff, live2_ff, esc2_ff;
   logic signed [P-1:0] pux_ff, puy_ff, pvx_ff, pvy_ff, psx_ff, psy_ff;
   logic signed [P-1:0] dot1_ff, dot2_ff, cr1_ff, cr2_ff;
   logic [2*RB-1:0] r2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_ff <= 1'b0;
      else s2_ff <= s1_ff;
      live2_ff <= live1_ff && (dz_ff <= D'(tol1_ff));
      esc2_ff <= esc1_ff;
      pux_ff <= ux_ff * ux_ff;
      puy_ff <= uy_ff * uy_ff;
      pvx_ff <= vx_ff * vx_ff;
      pvy_ff <= vy_ff * vy_ff;
      psx_ff <= sx_ff * sx_ff;
      psy_ff <= sy_ff * sy_ff;
      dot1_ff <= ux_ff * sx_ff;
      dot2_ff <= uy_ff * sy_ff;
      cr1_ff <= ux_ff * sy_ff;
      cr2_ff <= uy_ff * sx_ff;
      r2_ff <= r1_ff * r1_ff;
   end

   // stage 3: sums
   logic s3_ff, live3_ff, esc3_ff;
   logic [P:0] sa_ff, sb_ff, len_ff, crm_ff;
   logic signed [P:0] dot_ff;
   logic [2*RB-1:0] r2b_ff;
   logic signed [P:0] cr_in;
   assign cr_in = (P+1)'(cr1_ff) - (P+1)'(cr2_ff);
   always_ff @(posedge clock) begin
      if (reset) s3_ff <= 1'b0;
      else s3_ff <= s2_ff;
      live3_ff <= live2_ff;
      esc3_ff <= esc2_ff;
      sa_ff <= (P+1)'(unsigned'(pux_ff)) + (P+1)'(unsigned'(puy_ff));
      sb_ff <= (P+1)'(unsigned'(pvx_ff)) + (P+1)'(unsigned'(pvy_ff));
      len_ff <= (P+1)'(unsigned'(psx_ff)) + (P+1)'(unsigned'(psy_ff));
      dot_ff <= (P+1)'(dot1_ff) + (P+1)'(dot2_ff);
      crm_ff <= cr_in[P] ? (P+1)'(-cr_in) : (P+1)'(cr_in);
      r2b_ff <= r2_ff;
   end

   // stage 4: region decision, half-width partial products for the interior test
   logic s4_ff, live4_ff, interior_ff, near_ff;
   logic [2*K-1:0] pll_ff;
   logic [K+HB-1:0] plh_ff;
   logic [2*HB-1:0] phh_ff;
   logic [2*RB+K-1:0] rll_ff;
   logic [2*RB+HB-1:0] rlh_ff;
   logic sa_in_r, sb_in_r, esc_skip;
   logic [K-1:0] crl, lnl;
   logic [HB-1:0] crh, lnh;
   assign sa_in_r = sa_ff < (P+1)'(r2b_ff);
   assign sb_in_r = sb_ff < (P+1)'(r2b_ff);
   assign esc_skip = esc3_ff && sa_in_r && (sb_ff > sa_ff + (P+1)'(1));
   assign crl = crm_ff[K-1:0];
   assign crh = crm_ff[P:K];
   assign lnl = len_ff[K-1:0];
   assign lnh = len_ff[P:K];
   always_ff @(posedge clock) begin
      if (reset) s4_ff <= 1'b0;
      else s4_ff <= s3_ff;
      live4_ff <= live3_ff && !esc_skip;
      if (len_ff == '0 || dot_ff[P] || dot_ff == '0) begin
         interior_ff <= 1'b0;
         near_ff <= sa_in_r;
      end else if (unsigned'(dot_ff) >= len_ff) begin
         interior_ff <= 1'b0;
         near_ff <= sb_in_r;
      end else begin
         interior_ff <= 1'b1;
         near_ff <= sa_in_r;
      end
      pll_ff <= (2*K)'(crl) * (2*K)'(crl);
      plh_ff <= (K+HB)'(crl) * (K+HB)'(crh);
      phh_ff <= (2*HB)'(crh) * (2*HB)'(crh);
      rll_ff <= (2*RB+K)'(r2b_ff) * (2*RB+K)'(lnl);
      rlh_ff <= (2*RB+HB)'(r2b_ff) * (2*RB+HB)'(lnh);
   end

   // stage 5: recombine the partial products
   logic s5_ff, live5_ff, interior5_ff, near5_ff;
   logic [2*P+1:0] cr2sq_ff, rl_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_ff <= 1'b0;
      else s5_ff <= s4_ff;
      live5_ff <= live4_ff;
      interior5_ff <= interior_ff;
      near5_ff <= near_ff;
      cr2sq_ff <= ((2*P+2)'(phh_ff) << (2*K)) + ((2*P+2)'(plh_ff) << (K+1))
                  + (2*P+2)'(pll_ff);
      rl_ff <= ((2*P+2)'(rlh_ff) << K) + (2*P+2)'(rll_ff);
   end

   logic blk_in;
   assign blk_in = live5_ff && (interior5_ff ? (cr2sq_ff < rl_ff) : near5_ff);
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= s5_ff;
      out_block <= blk_in;
   end
endmodule

// File: design/soc_slot.sv
// One chain cell: holds one obstacle slot and shifts it to its neighbor while scanning.
// Depends on soc_pkg.
module soc_slot import soc_pkg::*; #(
   parameter int COORD_BITS = COORD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         clear,
   input  logic                         shift,
   input  logic signed [COORD_BITS-1:0] ld_x, ld_y, ld_z,
   input  logic [RAD_BITS-1:0]          ld_r,
   input  logic                         nb_v,
   input  logic signed [COORD_BITS-1:0] nb_x, nb_y, nb_z,
   input  logic [RAD_BITS-1:0]          nb_r,
   output logic                         v_ff,
   output logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff,
   output logic [RAD_BITS-1:0]          r_ff
);
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (shift) v_ff <= nb_v;
      else if (load) v_ff <= 1'b1;
      else if (clear) v_ff <= 1'b0;
      if (shift) begin
         x_ff <= nb_x; y_ff <= nb_y; z_ff <= nb_z; r_ff <= nb_r;
      end else if (load) begin
         x_ff <= ld_x; y_ff <= ld_y; z_ff <= ld_z; r_ff <= ld_r;
      end
   end
endmodule
